/* sv/ape_pkg.sv */
// ----------------------------------------------------------------------------
// Attitude packet encoder package
// Shared widths, fixed-point constants and frame layout for the encoder.
// ----------------------------------------------------------------------------
package ape_pkg;

  // Input angle: Q16 radians, signed
  localparam int unsigned AngW   = 24;
  // Radians to degrees factor, round(180/pi * 2^16), as a positive signed operand
  localparam int unsigned K_W    = 23;
  localparam logic signed [K_W-1:0] Rad2DegQ16 = 23'sd3754936;

  // Product of angle and factor: Q32 degrees
  localparam int unsigned ProdW  = AngW + K_W;
  // Wrapped degrees lie in [-180, 180) * 2^32
  localparam int unsigned WrapW  = 41;
  // Wrapped degrees times 100: Q32 centidegrees
  localparam int unsigned ScaleW = WrapW + 8;
  localparam logic signed [7:0] Hundred = 8'sd100;

  // Encoded angle code
  localparam int unsigned CodeW  = 16;

  // Degree thresholds in Q32
  localparam logic signed [ProdW-1:0] Deg180 = ProdW'(64'sd180 * 64'sd4294967296);
  localparam logic signed [ProdW-1:0] Deg360 = ProdW'(64'sd360 * 64'sd4294967296);
  localparam logic signed [ProdW-1:0] Deg540 = ProdW'(64'sd540 * 64'sd4294967296);
  localparam logic signed [ProdW-1:0] Deg720 = ProdW'(64'sd720 * 64'sd4294967296);

  // Rounding offset, one half in Q32
  localparam logic [ScaleW-1:0] HalfQ32 = ScaleW'(64'd2147483648);

  // Frame layout
  localparam int unsigned NumLanes = 3;
  localparam int unsigned FrameLen = 8;
  localparam int unsigned IdxW     = 3;
  localparam logic [7:0]  FrameHeader = 8'hA5;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameLen - 1);

  // Lane pipeline depth
  localparam int unsigned LaneStages = 4;

endpackage

/* sv/ape_lane.sv */
// ----------------------------------------------------------------------------
// Attitude packet encoder angle lane
// Converts one Q16 radian angle to a wrapped, rounded centidegree code in a
// four-stage pipeline: multiply, range check and wrap, scale, round.
// ----------------------------------------------------------------------------
module ape_lane (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [ape_pkg::AngW-1:0]   angle_i,
  input  logic                              invalid_i,
  output logic [ape_pkg::CodeW-1:0]         code_o
);

  // Stage 1: degrees in Q32
  logic signed [ape_pkg::ProdW-1:0]  prod_q;
  logic                              zero1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= angle_i * ape_pkg::Rad2DegQ16;
      zero1_q <= invalid_i;
    end
  end

  // Stage 2: range check and wrap into [-180, 180)
  logic                              oor;
  logic signed [ape_pkg::ProdW-1:0]  wrapped;
  logic signed [ape_pkg::WrapW-1:0]  wrap_q;
  logic                              zero2_q;

  always_comb begin
    oor = (prod_q > ape_pkg::Deg720) || (prod_q < -ape_pkg::Deg720);
    if (prod_q >= ape_pkg::Deg540) begin
      wrapped = prod_q - ape_pkg::Deg720;
    end else if (prod_q >= ape_pkg::Deg180) begin
      wrapped = prod_q - ape_pkg::Deg360;
    end else if (prod_q < -ape_pkg::Deg540) begin
      wrapped = prod_q + ape_pkg::Deg720;
    end else if (prod_q < -ape_pkg::Deg180) begin
      wrapped = prod_q + ape_pkg::Deg360;
    end else begin
      wrapped = prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wrap_q  <= wrapped[ape_pkg::WrapW-1:0];
      zero2_q <= zero1_q | oor;
    end
  end

  // Stage 3: scale to Q32 centidegrees
  logic signed [ape_pkg::ScaleW-1:0] scaled_q;
  logic                              zero3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scaled_q <= wrap_q * ape_pkg::Hundred;
      zero3_q  <= zero2_q;
    end
  end

  // Stage 4: round half away from zero; invalid or out-of-range angles give a zero code
  logic                              neg;
  logic [ape_pkg::ScaleW-1:0]        mag;
  logic [ape_pkg::ScaleW-1:0]        rnd;
  logic [ape_pkg::CodeW-1:0]         quo;
  logic [ape_pkg::CodeW-1:0]         code_d;
  logic [ape_pkg::CodeW-1:0]         code_q;

  always_comb begin
    neg    = scaled_q[ape_pkg::ScaleW-1];
    mag    = neg ? ape_pkg::ScaleW'(-scaled_q) : ape_pkg::ScaleW'(scaled_q);
    rnd    = mag + ape_pkg::HalfQ32;
    quo    = rnd[32 +: ape_pkg::CodeW];
    code_d = neg ? ape_pkg::CodeW'(-quo) : quo;
    if (zero3_q) begin
      code_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code_q <= code_d;
    end
  end

  assign code_o = code_q;

endmodule

/* sv/ape_frame.sv */
// ----------------------------------------------------------------------------
// Attitude packet encoder frame merge and serializer
// Merges the three lane codes into an 8-byte frame with checksum and sends it
// one byte per accepted item.
// ----------------------------------------------------------------------------
module ape_frame (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [ape_pkg::CodeW-1:0]   codes_i [ape_pkg::NumLanes],
  output logic                        ready_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  frame_byte_o,
  output logic                        last_byte_o
);

  logic [7:0]               bytes [ape_pkg::FrameLen];
  logic [7:0]               sum;
  logic [7:0]               frame_q [ape_pkg::FrameLen];
  logic [ape_pkg::IdxW-1:0] idx_q, idx_d;
  logic                     busy_q, busy_d;
  logic                     take;

  // Build frame bytes and additive checksum
  always_comb begin
    bytes[0] = ape_pkg::FrameHeader;
    for (int i = 0; i < ape_pkg::NumLanes; i++) begin
      bytes[1 + 2 * i] = codes_i[i][7:0];
      bytes[2 + 2 * i] = codes_i[i][15:8];
    end
    sum = '0;
    for (int i = 0; i < ape_pkg::FrameLen - 1; i++) begin
      sum = sum + bytes[i];
    end
    bytes[ape_pkg::FrameLen - 1] = sum;
  end

  // Hold frame bytes
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= bytes;
    end
  end

  assign take    = busy_q && !out_stall_i;
  assign ready_o = !busy_q || (take && idx_q == ape_pkg::LastIdx);

  // Advance byte index, start a new frame on load
  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    if (take) begin
      idx_d = idx_q + 1'b1;
      if (idx_q == ape_pkg::LastIdx) begin
        busy_d = 1'b0;
      end
    end
    if (load_i) begin
      idx_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  assign out_valid_o  = busy_q;
  assign frame_byte_o = frame_q[idx_q];
  assign last_byte_o  = (idx_q == ape_pkg::LastIdx);

endmodule

/* sv/attitude_packet_encoder.sv */
// ----------------------------------------------------------------------------
// Attitude packet encoder
// Three angle lanes convert pitch, roll and yaw to centidegree codes; a merge
// stage frames them with header and checksum and sends eight bytes per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | in_valid_i/in_stall_o  | pitch/roll/yaw_angle_i, invalid_mask_i
//  out     | output    | out_valid_o/out_stall_i| frame_byte_o, last_byte_o
//
//  An item passes four lane stages (multiply, wrap, scale, round) and then
//  comes out as 8 bytes, one per cycle unless out_stall_i holds them; the
//  single byte-wide output port sets the sustained item rate.
//  Reset clears valid bits and the serializer; payload registers are not reset.
//  A stalled output holds the lane pipeline once its last stage is full.
// ----------------------------------------------------------------------------
module attitude_packet_encoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [ape_pkg::AngW-1:0]   pitch_angle_i,
  input  logic signed [ape_pkg::AngW-1:0]   roll_angle_i,
  input  logic signed [ape_pkg::AngW-1:0]   yaw_angle_i,
  input  logic [2:0]                        invalid_mask_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        frame_byte_o,
  output logic                              last_byte_o
);

  logic [ape_pkg::LaneStages-1:0] vld_q;
  logic                           frm_ready;
  logic                           en;
  logic [ape_pkg::CodeW-1:0]      codes [ape_pkg::NumLanes];
  logic signed [ape_pkg::AngW-1:0] angles [ape_pkg::NumLanes];

  assign angles[0] = pitch_angle_i;
  assign angles[1] = roll_angle_i;
  assign angles[2] = yaw_angle_i;

  // Advance the lanes unless a finished item waits for the serializer
  assign en         = !vld_q[ape_pkg::LaneStages-1] || frm_ready;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ape_pkg::LaneStages-2:0], in_valid_i};
    end
  end

  // Angle lanes
  for (genvar g = 0; g < ape_pkg::NumLanes; g++) begin : g_lane
    ape_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .angle_i   (angles[g]),
      .invalid_i (invalid_mask_i[g]),
      .code_o    (codes[g])
    );
  end

  // Merge and serialize
  ape_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (vld_q[ape_pkg::LaneStages-1] && frm_ready),
    .codes_i      (codes),
    .ready_o      (frm_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

  // Input stalls only behind a full last lane stage
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> vld_q[ape_pkg::LaneStages-1])
    else $error("input stalled without a finished item waiting");

  // A frame continues after any byte but the last
  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_byte_o |=> out_valid_o)
    else $error("frame ended before its checksum byte");

  // The byte after a checksum opens a new frame with the header
  a_next_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_byte_o |=>
      !out_valid_o || (frame_byte_o == ape_pkg::FrameHeader && !last_byte_o))
    else $error("new frame does not start with header");

endmodule

/* test/attitude_packet_encoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attitude packet encoder testbench
// Sends attitude samples through the valid/stall input channel and checks each
// frame byte against an independent fixed-point predictor or typed-in codes. A
// directed table comes first, then random samples in three idle/stall phases.
// ----------------------------------------------------------------------------
module attitude_packet_encoder_tb;

  localparam longint Q32          = 64'sd4294967296;
  localparam longint RadToDeg     = 64'sd3754936;
  localparam longint HalfLsb      = 64'sd2147483648;
  localparam int     WatchdogMax  = 4000;
  localparam int     DrainCycles  = 20;
  localparam int     ItemsPerPhase = 67;
  localparam int     NumDirected  = 20;

  // Boundary angles in Q16 radians
  localparam int Ang180 = 205887;
  localparam int Ang360 = 411775;
  localparam int Ang540 = 617662;
  localparam int Ang720 = 823549;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef struct {
    int p;
    int r;
    int y;
    int mask;
    bit typed;
    int pc;
    int rc;
    int yc;
  } sample_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic signed [ape_pkg::AngW-1:0]  pitch_angle_i = '0;
  logic signed [ape_pkg::AngW-1:0]  roll_angle_i = '0;
  logic signed [ape_pkg::AngW-1:0]  yaw_angle_i = '0;
  logic [2:0]                       invalid_mask_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [7:0]                       frame_byte_o;
  logic                             last_byte_o;

  frame_byte_t pending_frame_bytes [$];
  frame_byte_t oldest_byte;
  int          sender_idle_pct = 28;
  int          receiver_stall_pct = 82;
  int          mismatches = 0;
  int          samples_sent = 0;
  int          directed_sent = 0;
  int          bytes_checked = 0;
  int          quiet_cycles = 0;

  attitude_packet_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pitch_angle_i  (pitch_angle_i),
    .roll_angle_i   (roll_angle_i),
    .yaw_angle_i    (yaw_angle_i),
    .invalid_mask_i (invalid_mask_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .last_byte_o    (last_byte_o)
  );

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Convert a Q16 radian angle to a centidegree code
  function automatic logic [15:0] to_centideg(logic signed [ape_pkg::AngW-1:0] ang,
                                              bit invalid);
    longint deg;
    longint cdeg;
    longint code;
    if (invalid) return 16'h0000;
    deg = longint'(ang) * RadToDeg;
    if (deg > 720 * Q32 || deg < -720 * Q32) return 16'h0000;
    while (deg >= 180 * Q32) deg -= 360 * Q32;
    while (deg < -180 * Q32) deg += 360 * Q32;
    cdeg = deg * 100;
    if (cdeg >= 0) begin
      code = (cdeg + HalfLsb) >>> 32;
    end else begin
      code = -((-cdeg + HalfLsb) >>> 32);
    end
    return code[15:0];
  endfunction

  // Build the eight frame bytes for three codes and queue them
  function automatic void queue_frame(logic [15:0] pc, logic [15:0] rc, logic [15:0] yc);
    logic [7:0] bytes [ape_pkg::FrameLen];
    logic [7:0] sum;
    sum = '0;
    bytes[0] = ape_pkg::FrameHeader;
    bytes[1] = pc[7:0];
    bytes[2] = pc[15:8];
    bytes[3] = rc[7:0];
    bytes[4] = rc[15:8];
    bytes[5] = yc[7:0];
    bytes[6] = yc[15:8];
    for (int i = 0; i < ape_pkg::FrameLen - 1; i++) sum += bytes[i];
    bytes[ape_pkg::FrameLen-1] = sum;
    for (int i = 0; i < ape_pkg::FrameLen; i++) begin
      pending_frame_bytes.push_back('{data: bytes[i],
                                      last: (i == ape_pkg::FrameLen - 1)});
    end
  endfunction

  // Pick a random angle, weighted toward the interesting ranges
  function automatic logic signed [ape_pkg::AngW-1:0] random_angle();
    int sel;
    int base;
    sel = $urandom_range(9);
    case (sel)
      6: begin
        base = $urandom_range(1) ? Ang180 : -Ang180;
        return ape_pkg::AngW'(base + int'($urandom_range(6)) - 3);
      end
      7: begin
        case ($urandom_range(2))
          0: base = Ang720;
          1: base = Ang540;
          default: base = Ang360;
        endcase
        if ($urandom_range(1)) base = -base;
        return ape_pkg::AngW'(base + int'($urandom_range(4)) - 2);
      end
      8: return ape_pkg::AngW'($urandom);
      9: return ape_pkg::AngW'(int'($urandom_range(600)) - 300);
      default: return ape_pkg::AngW'(int'($urandom_range(2 * Ang720 + 2)) - Ang720 - 1);
    endcase
  endfunction

  // Offer one sample, hold it until accepted, then queue its frame
  task automatic send_sample(input logic signed [ape_pkg::AngW-1:0] p,
                             input logic signed [ape_pkg::AngW-1:0] r,
                             input logic signed [ape_pkg::AngW-1:0] y,
                             input logic [2:0] m,
                             input logic [15:0] pc, input logic [15:0] rc,
                             input logic [15:0] yc);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pitch_angle_i  <= p;
    roll_angle_i   <= r;
    yaw_angle_i    <= y;
    invalid_mask_i <= m;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    queue_frame(pc, rc, yc);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every queued frame byte has come out
  task automatic drain_frames();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_frame_bytes.size() != 0) @(negedge clk_i);
  endtask

  // Receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Check each accepted frame byte against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_frame_bytes.size() == 0) begin
        $error("unexpected frame byte %h (last_byte %b)", frame_byte_o, last_byte_o);
        mismatches++;
      end else begin
        oldest_byte = pending_frame_bytes.pop_front();
        bytes_checked++;
        if (frame_byte_o !== oldest_byte.data) begin
          $error("frame_byte: expected %h, got %h", oldest_byte.data, frame_byte_o);
          mismatches++;
        end
        if (last_byte_o !== oldest_byte.last) begin
          $error("last_byte: expected %b, got %b", oldest_byte.last, last_byte_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogMax) begin
        $display("watchdog expired with %0d frame bytes outstanding",
                 pending_frame_bytes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin
    sample_row_t directed_rows [NumDirected];
    logic signed [ape_pkg::AngW-1:0] p, r, y;
    logic [2:0] m;

    directed_rows = '{
      // all zero, and every angle flagged invalid
      '{0, 0, 0, 0, 1, 0, 0, 0},
      '{8388607, 8388607, 8388607, 7, 1, 0, 0, 0},
      // field extremes are far beyond 720 degrees
      '{8388607, -8388608, 8388607, 0, 1, 0, 0, 0},
      '{-8388608, -8388608, -8388608, 0, 1, 0, 0, 0},
      '{5592405, -5592406, 8388607, 0, 1, 0, 0, 0},
      '{5592405, -5592406, 8388607, 7, 1, 0, 0, 0},
      // just inside and just outside 720 degrees
      '{Ang720, -Ang720, Ang720 + 1, 0, 0, 0, 0, 0},
      '{-Ang720 - 1, Ang720 + 1, -Ang720, 0, 0, 0, 0, 0},
      // around the 180 degree wrap point
      '{Ang180, Ang180 + 1, -Ang180, 0, 0, 0, 0, 0},
      '{-Ang180 - 1, -Ang180 + 1, Ang180 + 2, 0, 0, 0, 0, 0},
      // 90, 360 and 540 degrees
      '{102944, -102944, Ang360, 0, 0, 0, 0, 0},
      '{Ang540, -Ang540, Ang540 + 1, 0, 0, 0, 0, 0},
      // tiny angles and one radian
      '{1, -1, 2, 0, 0, 0, 0, 0},
      '{-2, 65536, -65536, 0, 0, 0, 0, 0},
      // one invalid flag at a time, then pairs
      '{Ang720, Ang720, Ang720, 1, 0, 0, 0, 0},
      '{-Ang540, 300000, -300000, 2, 0, 0, 0, 0},
      '{123456, -654321, 777777, 4, 0, 0, 0, 0},
      '{Ang180, -Ang180, 42, 3, 0, 0, 0, 0},
      '{-777777, 500000, -Ang360, 5, 0, 0, 0, 0},
      '{-1, 1, -Ang720, 6, 0, 0, 0, 0}
    };

    // Hold reset, then release it
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      p = ape_pkg::AngW'(directed_rows[i].p);
      r = ape_pkg::AngW'(directed_rows[i].r);
      y = ape_pkg::AngW'(directed_rows[i].y);
      m = 3'(directed_rows[i].mask);
      if (directed_rows[i].typed) begin
        send_sample(p, r, y, m, 16'(directed_rows[i].pc), 16'(directed_rows[i].rc),
                    16'(directed_rows[i].yc));
      end else begin
        send_sample(p, r, y, m, to_centideg(p, m[0]), to_centideg(r, m[1]),
                    to_centideg(y, m[2]));
      end
    end
    directed_sent = samples_sent;
    drain_frames();

    // Random samples in three idle/stall phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 28;
          receiver_stall_pct = 82;
        end
        1: begin
          sender_idle_pct    = 82;
          receiver_stall_pct = 28;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        p = random_angle();
        r = random_angle();
        y = random_angle();
        m = ($urandom_range(9) < 6) ? 3'b000 : 3'($urandom_range(7));
        send_sample(p, r, y, m, to_centideg(p, m[0]), to_centideg(r, m[1]),
                    to_centideg(y, m[2]));
      end
      drain_frames();
    end

    // Let the pipeline settle, then report
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d attitude samples (%0d directed, %0d random) and checked %0d frame bytes",
             samples_sent, directed_sent, samples_sent - directed_sent, bytes_checked);
    $display("Phases: sender-idle heavy, receiver-stall heavy, and back-to-back; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
